[rtl/prefix_expression_evaluator_top_defines.svh]
// Assertion macros used by the checker of the prefix expression evaluator
`ifndef PREFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define PREFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEE_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pee assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pee assertion failed");

`endif

[rtl/pee_pkg.sv]
// Package: types, constants and helpers of the prefix expression evaluator
`timescale 1ns / 1ps
package pee_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int FRAC_BITS   = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DIV_W       = 32 + FRAC_BITS;
  localparam int CNT_W       = $clog2(DIV_W + 1);

  // symbol modes
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_TERM = 3'd4;

  // stack entry tags
  localparam logic [2:0] TAG_OPERAND = 3'd0;
  localparam logic [2:0] TAG_ADD     = 3'd1;
  localparam logic [2:0] TAG_SUB     = 3'd2;
  localparam logic [2:0] TAG_MUL     = 3'd3;
  localparam logic [2:0] TAG_DIV     = 3'd4;

  localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FETCH,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               malformed;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic accept;
    logic push_op;
    logic push_cur;
    logic set_err;
    logic latch_left;
    logic fetch;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       last;
    logic       top_operand;
    logic       sp_lt2;
    logic [2:0] op_tag;
    logic       rhs_zero;
    logic       div_done;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    if (v > Q_MAX64) begin
      r.val = 32'sh7FFF_FFFF;
      r.hit = 1'b1;
    end else if (v < Q_MIN64) begin
      r.val = 32'sh8000_0000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/pee_ctrl.sv]
// Controller state machine of the prefix expression evaluator
`timescale 1ns / 1ps
module pee_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pee_pkg::stat_t  stat_i,
  output pee_pkg::ctrl_t  ctrl_o
);

  pee_pkg::state_e state_q, state_d;
  pee_pkg::state_e after_sym;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pee_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign after_sym = stat_i.last ? pee_pkg::ST_EMIT : pee_pkg::ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pee_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pee_pkg::ST_DISPATCH;
      end
      pee_pkg::ST_DISPATCH: begin
        if (stat_i.mode == pee_pkg::MODE_TERM) state_d = pee_pkg::ST_SCAN;
        else state_d = after_sym;
      end
      pee_pkg::ST_SCAN: begin
        if (!stat_i.top_operand || stat_i.sp_lt2) state_d = after_sym;
        else state_d = pee_pkg::ST_FETCH;
      end
      pee_pkg::ST_FETCH: begin
        if (stat_i.op_tag == pee_pkg::TAG_MUL) state_d = pee_pkg::ST_MUL;
        else if (stat_i.op_tag == pee_pkg::TAG_DIV && !stat_i.rhs_zero) state_d = pee_pkg::ST_DIV;
        else state_d = pee_pkg::ST_SCAN;
      end
      pee_pkg::ST_MUL: begin
        state_d = pee_pkg::ST_SCAN;
      end
      pee_pkg::ST_DIV: begin
        if (stat_i.div_done) state_d = pee_pkg::ST_SCAN;
      end
      pee_pkg::ST_EMIT: begin
        if (stat_i.out_free) state_d = pee_pkg::ST_IDLE;
      end
      default: state_d = pee_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pee_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctrl_o.accept = in_valid_i;
      end
      pee_pkg::ST_DISPATCH: begin
        if (stat_i.mode < pee_pkg::MODE_TERM) ctrl_o.push_op = 1'b1;
        else if (stat_i.mode != pee_pkg::MODE_TERM) ctrl_o.set_err = 1'b1;
      end
      pee_pkg::ST_SCAN: begin
        if (!stat_i.top_operand) ctrl_o.push_cur = 1'b1;
        else if (stat_i.sp_lt2) ctrl_o.set_err = 1'b1;
        else ctrl_o.latch_left = 1'b1;
      end
      pee_pkg::ST_FETCH: ctrl_o.fetch = 1'b1;
      pee_pkg::ST_MUL:   ctrl_o.mul_fin = 1'b1;
      pee_pkg::ST_DIV: begin
        if (stat_i.div_done) ctrl_o.div_fin = 1'b1;
        else ctrl_o.div_step = 1'b1;
      end
      pee_pkg::ST_EMIT:  ctrl_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/pee_datapath.sv]
// Datapath: operand stack, arithmetic, serial divider and output register
`timescale 1ns / 1ps
module pee_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pee_pkg::in_t    in_data_i,
  input  pee_pkg::ctrl_t  ctrl_i,
  output pee_pkg::stat_t  stat_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pee_pkg::out_t   out_data_o
);

  logic [2:0]         tag_q [pee_pkg::STACK_DEPTH];
  logic signed [31:0] val_q [pee_pkg::STACK_DEPTH];
  logic [pee_pkg::SP_W-1:0]  sp_q;
  logic                      err_q, satf_q;
  logic [2:0]                mode_q;
  logic                      last_q;
  logic signed [31:0]        cur_q, left_q;
  logic signed [63:0]        prod_q;
  logic [31:0]               rem_q, dvs_q;
  logic [pee_pkg::DIV_W-1:0] quo_q;
  logic                      neg_q;
  logic [pee_pkg::CNT_W-1:0] cnt_q;
  logic                      out_valid_q;
  pee_pkg::out_t             out_q;

  logic [pee_pkg::SP_W-1:0]  rd_ptr;
  logic [pee_pkg::IDX_W-1:0] rd_idx, wr_idx;
  logic [2:0]                rd_tag;
  logic                      full;
  logic                      push_en;
  logic [2:0]                push_tag;
  logic signed [31:0]        push_val;
  logic signed [63:0]        prod_d, q_signed;
  logic [32:0]               rem_sh;
  logic                      ge;
  logic [31:0]               mag_l, mag_r;
  logic                      good;
  pee_pkg::sat_t             s_add, s_sub, s_mul, s_div;

  assign rd_ptr = ctrl_i.fetch ? sp_q - pee_pkg::SP_W'(2) : sp_q - pee_pkg::SP_W'(1);
  assign rd_idx = rd_ptr[pee_pkg::IDX_W-1:0];
  assign wr_idx = sp_q[pee_pkg::IDX_W-1:0];
  assign rd_tag = tag_q[rd_idx];
  assign full   = (sp_q == pee_pkg::SP_W'(pee_pkg::STACK_DEPTH));

  assign push_en  = ctrl_i.push_op | ctrl_i.push_cur;
  assign push_tag = ctrl_i.push_op ? mode_q + 3'd1 : pee_pkg::TAG_OPERAND;
  assign push_val = ctrl_i.push_op ? 32'sd0 : cur_q;

  assign s_add  = pee_pkg::sat64(64'(left_q) + 64'(cur_q));
  assign s_sub  = pee_pkg::sat64(64'(left_q) - 64'(cur_q));
  assign prod_d = left_q * cur_q;
  assign s_mul  = pee_pkg::sat64(prod_q >>> pee_pkg::FRAC_BITS);
  assign q_signed = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
  assign s_div  = pee_pkg::sat64(q_signed);

  assign mag_l = left_q[31] ? 32'(-left_q) : 32'(left_q);
  assign mag_r = cur_q[31] ? 32'(-cur_q) : 32'(cur_q);

  assign rem_sh = {rem_q, quo_q[pee_pkg::DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  assign good = (sp_q == pee_pkg::SP_W'(1)) && (tag_q[0] == pee_pkg::TAG_OPERAND);

  // stack entries hold no reset; only entries below the pointer are read
  always_ff @(posedge clk_i) begin
    if (push_en && !full) begin
      tag_q[wr_idx] <= push_tag;
      val_q[wr_idx] <= push_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      mode_q <= in_data_i.mode;
      last_q <= in_data_i.last;
      cur_q  <= in_data_i.operand_value;
    end
    if (ctrl_i.latch_left) left_q <= val_q[rd_idx];
    if (ctrl_i.fetch) begin
      case (rd_tag)
        pee_pkg::TAG_ADD: cur_q <= s_add.val;
        pee_pkg::TAG_SUB: cur_q <= s_sub.val;
        pee_pkg::TAG_MUL: prod_q <= prod_d;
        pee_pkg::TAG_DIV: begin
          if (cur_q == 32'sd0) begin
            cur_q <= 32'(64'sd1 <<< pee_pkg::FRAC_BITS);
          end else begin
            neg_q <= left_q[31] ^ cur_q[31];
            quo_q <= pee_pkg::DIV_W'(mag_l) << pee_pkg::FRAC_BITS;
            rem_q <= '0;
            dvs_q <= mag_r;
          end
        end
        default: ;
      endcase
    end
    if (ctrl_i.mul_fin) cur_q <= s_mul.val;
    if (ctrl_i.div_step) begin
      rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
      quo_q <= {quo_q[pee_pkg::DIV_W-2:0], ge};
    end
    if (ctrl_i.div_fin) cur_q <= s_div.val;
    if (ctrl_i.emit) begin
      out_q.result_value <= good ? val_q[0] : 32'sd0;
      out_q.malformed    <= !good || err_q;
      out_q.saturated    <= satf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= 1'b0;
      satf_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_en) begin
        if (full) err_q <= 1'b1;
        else sp_q <= sp_q + pee_pkg::SP_W'(1);
      end
      if (ctrl_i.set_err) err_q <= 1'b1;
      if (ctrl_i.fetch) begin
        sp_q <= sp_q - pee_pkg::SP_W'(2);
        if (rd_tag == pee_pkg::TAG_ADD && s_add.hit) satf_q <= 1'b1;
        if (rd_tag == pee_pkg::TAG_SUB && s_sub.hit) satf_q <= 1'b1;
        if (rd_tag == pee_pkg::TAG_DIV) cnt_q <= pee_pkg::CNT_W'(pee_pkg::DIV_W);
      end
      if (ctrl_i.mul_fin && s_mul.hit) satf_q <= 1'b1;
      if (ctrl_i.div_step) cnt_q <= cnt_q - pee_pkg::CNT_W'(1);
      if (ctrl_i.div_fin && s_div.hit) satf_q <= 1'b1;
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
        sp_q        <= '0;
        err_q       <= 1'b0;
        satf_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.last        = last_q;
  assign stat_o.top_operand = (sp_q != '0) && (rd_tag == pee_pkg::TAG_OPERAND);
  assign stat_o.sp_lt2      = (sp_q < pee_pkg::SP_W'(2));
  assign stat_o.op_tag      = rd_tag;
  assign stat_o.rhs_zero    = (cur_q == 32'sd0);
  assign stat_o.div_done    = (cnt_q == '0);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/prefix_expression_evaluator_top.sv]
// Top level of the prefix expression evaluator
`timescale 1ns / 1ps
// channel | dir | handshake            | beat
// in      | in  | in_valid_i/in_stall_o  | pee_pkg::in_t  (mode, operand_value, last)
// out     | out | out_valid_o/out_stall_i| pee_pkg::out_t (result_value, malformed, saturated)
//
// One symbol at a time: an operator is pushed in DISPATCH, a terminal walks SCAN and
// FETCH per reduction, MUL per multiply, 48-step serial DIV per nonzero divide.
// A last symbol then passes through EMIT; the result register frees the input side
// while a result waits. Reset clears the stack pointer and flags; stack contents
// have no reset. out_stall_i only holds the last symbol of the next expression.
module prefix_expression_evaluator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pee_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pee_pkg::out_t out_data_o
);

  pee_pkg::ctrl_t ctrl;
  pee_pkg::stat_t stat;

  pee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pee_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/pee_checker.sv]
// Port-level checker of the prefix expression evaluator, bound to the top level
`timescale 1ns / 1ps
`include "prefix_expression_evaluator_top_defines.svh"
module pee_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pee_pkg::out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  `PEE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `PEE_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, in_stall_o)
  `PEE_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_beat, !$rose(out_valid_o))

endmodule

bind prefix_expression_evaluator_top pee_checker u_pee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[sim/tb_prefix_expression_evaluator_top.sv]
// Self-checking testbench for the prefix expression evaluator
`timescale 1ns / 1ps
module tb_prefix_expression_evaluator_top;
  import pee_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  prefix_expression_evaluator_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // evaluator shadow state
  logic [2:0]         sh_tag [STACK_DEPTH];
  logic signed [31:0] sh_val [STACK_DEPTH];
  int                 sh_sp;
  logic               sh_err, sh_sat;

  in_t  symbol_q[$];
  out_t value_q[$];
  int   n_errors;
  bit   stim_done;
  int   cyc;

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
    if (v > Q_MAX64) begin sh_sat = 1'b1; return 32'sh7FFF_FFFF; end
    if (v < Q_MIN64) begin sh_sat = 1'b1; return 32'sh8000_0000; end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] combine(input logic [2:0] tag,
      input logic signed [31:0] lhs, input logic signed [31:0] rhs);
    logic signed [63:0] a, b;
    a = lhs;
    b = rhs;
    case (tag)
      TAG_ADD: return clamp(a + b);
      TAG_SUB: return clamp(a - b);
      TAG_MUL: return clamp((a * b) >>> FRAC_BITS);  // arithmetic shift floors
      TAG_DIV: begin
        if (b == 0) return 32'sd1 <<< FRAC_BITS;
        return clamp((a <<< FRAC_BITS) / b);
      end
      default: return rhs;
    endcase
  endfunction

  function automatic void push_entry(input logic [2:0] tag, input logic signed [31:0] v);
    if (sh_sp >= STACK_DEPTH) begin
      sh_err = 1'b1;
      return;
    end
    sh_tag[sh_sp] = tag;
    sh_val[sh_sp] = v;
    sh_sp++;
  endfunction

  function automatic void predict_symbol(input in_t s);
    logic signed [31:0] v;
    out_t r;
    logic ok;
    logic drop;
    v = s.operand_value;
    drop = 1'b0;
    if (s.mode < MODE_TERM) push_entry(s.mode + 3'd1, '0);
    else if (s.mode == MODE_TERM) begin
      while (!drop && sh_sp >= 1 && sh_tag[sh_sp-1] == TAG_OPERAND) begin
        // a lone finished operand: the terminal is dropped
        if (sh_sp < 2) begin
          sh_err = 1'b1;
          drop = 1'b1;
        end else begin
          v = combine(sh_tag[sh_sp-2], sh_val[sh_sp-1], v);
          sh_sp -= 2;
        end
      end
      if (!drop) push_entry(TAG_OPERAND, v);
    end else sh_err = 1'b1;
    if (s.last) begin
      ok = (sh_sp == 1) && (sh_tag[0] == TAG_OPERAND);
      r.result_value = ok ? sh_val[0] : 32'sd0;
      r.malformed = !ok || sh_err;
      r.saturated = sh_sat;
      value_q.push_back(r);
      sh_sp = 0;
      sh_err = 1'b0;
      sh_sat = 1'b0;
    end
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 8'hFF) << FRAC_BITS) - (32'sd128 <<< FRAC_BITS);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t mk(input logic [2:0] m, input logic signed [31:0] v,
      input logic l);
    in_t s;
    s.mode = m;
    s.operand_value = v;
    s.last = l;
    return s;
  endfunction

  // well-formed random tree, depth-limited so the stack stays within bounds
  function automatic void gen_tree(input int depth);
    if (depth == 0 || $urandom_range(0, 2) == 0)
      symbol_q.push_back(mk(MODE_TERM, rand_value(), 1'b0));
    else begin
      symbol_q.push_back(mk(3'($urandom_range(0, 3)), $urandom, 1'b0));
      gen_tree(depth - 1);
      gen_tree(depth - 1);
    end
  endfunction

  function automatic void close_expr();
    in_t s;
    s = symbol_q.pop_back();
    s.last = 1'b1;
    symbol_q.push_back(s);
  endfunction

  initial begin
    logic [2:0] m;
    sh_sp = 0;
    sh_err = 1'b0;
    sh_sat = 1'b0;
    // directed: each operator with edge operands, zero divisor, odd cases
    for (int op = 0; op < 4; op++) begin
      symbol_q.push_back(mk(3'(op), 32'sd0, 1'b0));
      symbol_q.push_back(mk(MODE_TERM, 32'sh7FFF_FFFF, 1'b0));
      symbol_q.push_back(mk(MODE_TERM, (op == 3) ? 32'sd0 : 32'sh8000_0000, 1'b1));
    end
    symbol_q.push_back(mk(MODE_DIV, 0, 1'b0));
    symbol_q.push_back(mk(MODE_TERM, 32'sh8000_0000, 1'b0));
    symbol_q.push_back(mk(MODE_TERM, -32'sd1, 1'b1));
    symbol_q.push_back(mk(3'd7, 32'sh5555_AAAA, 1'b1));          // unknown mode
    symbol_q.push_back(mk(MODE_TERM, 32'sd5, 1'b0));
    symbol_q.push_back(mk(MODE_TERM, 32'sd6, 1'b1));             // terminal after complete
    symbol_q.push_back(mk(MODE_ADD, 0, 1'b1));                   // incomplete
    for (int i = 0; i < 9; i++) symbol_q.push_back(mk(MODE_MUL, 0, 1'b0));
    symbol_q.push_back(mk(MODE_TERM, 32'sd1, 1'b1));             // overflow
    while (symbol_q.size() < 1700) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_tree($urandom_range(1, 3));
        close_expr();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          m = 3'($urandom_range(0, 7));
          symbol_q.push_back(mk(m, $urandom, 1'b0));
        end
        if ($urandom_range(0, 1)) close_expr();
      end
    end
    symbol_q.push_back(mk(MODE_TERM, 32'sd3, 1'b1));
  end

  // idling switches off for a stretch in the middle of the run
  function automatic bit idle_now();
    if (cyc > 6000 && cyc < 14000) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  // stimulus driver
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) predict_symbol(in_data_i);
        if (symbol_q.size() != 0 && !idle_now()) begin
          in_data_i  <= symbol_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          if (symbol_q.size() == 0) stim_done <= 1'b1;
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (value_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data_o);
        n_errors++;
      end else begin
        e = value_q.pop_front();
        if (out_data_o.result_value !== e.result_value) begin
          $display("%0t: result_value exp %h got %h", $realtime, e.result_value,
                   out_data_o.result_value);
          n_errors++;
        end
        if (out_data_o.malformed !== e.malformed) begin
          $display("%0t: malformed exp %b got %b", $realtime, e.malformed,
                   out_data_o.malformed);
          n_errors++;
        end
        if (out_data_o.saturated !== e.saturated) begin
          $display("%0t: saturated exp %b got %b", $realtime, e.saturated,
                   out_data_o.saturated);
          n_errors++;
        end
      end
    end
  end

  initial begin
    cyc = 0;
    n_errors = 0;
    stim_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && value_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
